FILE: hdl/imu_yaw_compensated_window_mean_assert.svh
// Assertion macros for the IMU yaw-compensated window mean block.
// Used by the port checker; no other dependencies.
`ifndef IMU_YAW_COMPENSATED_WINDOW_MEAN_ASSERT_SVH
`define IMU_YAW_COMPENSATED_WINDOW_MEAN_ASSERT_SVH

// Antecedent implies consequent in the next cycle.
`define IYWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("iywm assertion failed");

// Antecedent implies consequent in the same cycle.
`define IYWM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("iywm assertion failed");

`endif

FILE: hdl/iywm_pkg.sv
// Shared types, constants and tables for the IMU yaw-compensated window mean.
// No dependencies.
`default_nettype none
package iywm_pkg;

    localparam int RING_DEPTH = 64;
    localparam int RING_AW    = 6;
    localparam int RING_DW    = 80;
    localparam int CNT_W      = 7;
    localparam int SUM_W      = 23;
    localparam int MAG_W      = 22;
    localparam int NUM_CH     = 5;

    localparam logic [CNT_W-1:0] CORDIC_LAST = 7'd15;
    localparam logic [CNT_W-1:0] DIV_LAST    = 7'd21;

    localparam logic [7:0] REG_WINDOW_SIZE = 8'd0;
    localparam logic [7:0] REG_YAW_GAIN    = 8'd1;

    localparam logic [6:0]  WIN_RESET  = 7'd16;
    localparam logic [6:0]  WIN_MAX    = 7'd64;
    localparam logic [15:0] GAIN_RESET = 16'd47722;

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    typedef struct packed {
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic [9:0]         elapsed_ms;
    } t_in;

    typedef struct packed {
        logic signed [15:0] mean_accel_x;
        logic signed [15:0] mean_accel_y;
        logic signed [15:0] mean_rate_x;
        logic signed [15:0] mean_rate_y;
        logic signed [15:0] mean_rate_z;
        logic [31:0]        heading;
    } t_out;

    typedef struct packed {
        logic             load;
        logic             mul1;
        logic             mul2;
        logic             yaw_add;
        logic             cordic_init;
        logic             cordic_step;
        logic             scale;
        logic             rot1;
        logic             rot2;
        logic             rot3;
        logic             sum_rd;
        logic             sum_acc;
        logic             div_init;
        logic             div_step;
        logic             out_load;
        logic [CNT_W-1:0] cnt;
    } t_cmd;

    typedef struct packed {
        logic [6:0] w;
    } t_sts;

    function automatic logic [31:0] atan_lut(input logic [3:0] idx);
        logic [31:0] v;
        unique case (idx)
            4'd0:    v = 32'h20000000;
            4'd1:    v = 32'h12E4051E;
            4'd2:    v = 32'h09FB385B;
            4'd3:    v = 32'h051111D4;
            4'd4:    v = 32'h028B0D43;
            4'd5:    v = 32'h0145D7E1;
            4'd6:    v = 32'h00A2F61E;
            4'd7:    v = 32'h00517C55;
            4'd8:    v = 32'h0028BE53;
            4'd9:    v = 32'h00145F2F;
            4'd10:   v = 32'h000A2F98;
            4'd11:   v = 32'h000517CC;
            4'd12:   v = 32'h00028BE6;
            4'd13:   v = 32'h000145F3;
            4'd14:   v = 32'h0000A2FA;
            4'd15:   v = 32'h0000517D;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/iywm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module iywm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: hdl/iywm_ctrl.sv
// Sequencer for the IMU yaw-compensated window mean.
// Depends on iywm_pkg; drives datapath commands, owns both handshakes.
`default_nettype none
module iywm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    input  wire iywm_pkg::t_sts i_sts,
    output iywm_pkg::t_cmd     o_cmd
);
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MUL1   = 4'd1;
    localparam logic [3:0] ST_MUL2   = 4'd2;
    localparam logic [3:0] ST_YAW    = 4'd3;
    localparam logic [3:0] ST_CINIT  = 4'd4;
    localparam logic [3:0] ST_CORDIC = 4'd5;
    localparam logic [3:0] ST_SCALE  = 4'd6;
    localparam logic [3:0] ST_ROT1   = 4'd7;
    localparam logic [3:0] ST_ROT2   = 4'd8;
    localparam logic [3:0] ST_ROT3   = 4'd9;
    localparam logic [3:0] ST_SUM    = 4'd10;
    localparam logic [3:0] ST_DIVI   = 4'd11;
    localparam logic [3:0] ST_DIV    = 4'd12;
    localparam logic [3:0] ST_DONE   = 4'd13;

    logic [3:0]                   r_state, n_state;
    logic [iywm_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                         r_out_valid, n_out_valid;
    logic                         out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + 7'd1;
        o_cmd   = '0;
        o_cmd.cnt = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL1;
                end
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_YAW;
            end
            ST_YAW: begin
                o_cmd.yaw_add = 1'b1;
                n_state       = ST_CINIT;
            end
            ST_CINIT: begin
                o_cmd.cordic_init = 1'b1;
                n_cnt             = '0;
                n_state           = ST_CORDIC;
            end
            ST_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                if (r_cnt == iywm_pkg::CORDIC_LAST) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_ROT1;
            end
            ST_ROT1: begin
                o_cmd.rot1 = 1'b1;
                n_state    = ST_ROT2;
            end
            ST_ROT2: begin
                o_cmd.rot2 = 1'b1;
                n_state    = ST_ROT3;
            end
            ST_ROT3: begin
                o_cmd.rot3 = 1'b1;
                n_cnt      = '0;
                n_state    = ST_SUM;
            end
            ST_SUM: begin
                // read entry cnt, add the entry read in the cycle before
                o_cmd.sum_rd  = (r_cnt != i_sts.w);
                o_cmd.sum_acc = (r_cnt != '0);
                if (r_cnt == i_sts.w) begin
                    n_state = ST_DIVI;
                end
            end
            ST_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == iywm_pkg::DIV_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

FILE: hdl/iywm_dp.sv
// Datapath: yaw integrator, CORDIC, rotation, ring buffer, window sums, dividers.
// Depends on iywm_pkg and iywm_ram; driven by iywm_ctrl commands.
`default_nettype none
module iywm_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [7:0]     i_cfg_index,
    input  wire logic [15:0]    i_cfg_data,
    input  wire iywm_pkg::t_in  i_in_data,
    input  wire iywm_pkg::t_cmd i_cmd,
    output iywm_pkg::t_sts      o_sts,
    output iywm_pkg::t_out      o_out_data
);
    localparam int NCH = iywm_pkg::NUM_CH;

    logic [6:0]               r_win_size;
    logic [15:0]              r_yaw_gain;
    iywm_pkg::t_in            r_in;
    logic [6:0]               r_w;
    logic signed [25:0]       r_prod1;
    logic signed [42:0]       r_prod2;
    logic [31:0]              r_yaw;
    logic signed [33:0]       r_x, r_y, r_z;
    logic                     r_neg;
    logic signed [15:0]       r_cos, r_sin;
    logic signed [31:0]       r_p0, r_p1;
    logic signed [15:0]       r_rx;
    logic [iywm_pkg::RING_AW-1:0]    r_slot;
    logic [iywm_pkg::RING_DEPTH-1:0] r_valid;
    logic                     r_rd_vld;
    logic signed [iywm_pkg::SUM_W-1:0] r_acc [NCH];
    logic [iywm_pkg::MAG_W-1:0] r_mag [NCH];
    logic [7:0]               r_rem [NCH];
    logic                     r_sgn [NCH];
    iywm_pkg::t_out           r_out;

    logic [iywm_pkg::RING_DW-1:0] rd_data;
    logic [iywm_pkg::RING_DW-1:0] wr_data;
    logic [iywm_pkg::RING_AW-1:0] rd_addr;
    logic signed [15:0]       ry;
    logic signed [32:0]       sum01, dif01;
    logic signed [33:0]       xs, ys;
    logic signed [33:0]       atan_s;
    logic [31:0]              fold;
    logic                     fold_neg;
    logic [6:0]               slot_inc;
    logic signed [iywm_pkg::SUM_W-1:0] acc_add [NCH];
    logic [7:0]               rem_sh [NCH];
    logic [iywm_pkg::MAG_W-1:0] mag_sh [NCH];
    logic [15:0]              mean [NCH];

    function automatic logic signed [15:0] trig_round(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v + 34'sd16384) >>> 15;
        if (t > 34'sd32767) begin
            return 16'sd32767;
        end else if (t < -34'sd32767) begin
            return -16'sd32767;
        end
        return t[15:0];
    endfunction

    function automatic logic signed [15:0] rot_round(input logic signed [32:0] v);
        logic signed [32:0] t;
        t = (v + 33'sd16384) >>> 15;
        if (t > 33'sd32767) begin
            return 16'sd32767;
        end else if (t < -33'sd32768) begin
            return -16'sd32768;
        end
        return t[15:0];
    endfunction

    // ring buffer: {gz, gy, gx, ry, rx}
    iywm_ram #(
        .WIDTH(iywm_pkg::RING_DW),
        .DEPTH(iywm_pkg::RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (i_cmd.rot3),
        .i_waddr(r_slot),
        .i_wdata(wr_data),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    always_comb begin
        rd_addr  = i_cmd.cnt[iywm_pkg::RING_AW-1:0];
        sum01    = 33'(r_p0) + 33'(r_p1);
        dif01    = 33'(r_p0) - 33'(r_p1);
        ry       = rot_round(dif01);
        wr_data  = {r_in.gyro_z, r_in.gyro_y, r_in.gyro_x, ry, r_rx};
        xs       = r_x >>> i_cmd.cnt[3:0];
        ys       = r_y >>> i_cmd.cnt[3:0];
        atan_s   = $signed({2'b00, iywm_pkg::atan_lut(i_cmd.cnt[3:0])});
        fold_neg = r_yaw[31] ^ r_yaw[30];
        fold     = {r_yaw[31] ^ fold_neg, r_yaw[30:0]};
        slot_inc = {1'b0, r_slot} + 7'd1;
        for (int k = 0; k < NCH; k++) begin
            acc_add[k] = r_rd_vld
                ? iywm_pkg::SUM_W'($signed(rd_data[k*16 +: 16])) : '0;
            rem_sh[k]  = {r_rem[k][6:0], r_mag[k][iywm_pkg::MAG_W-1]};
            mag_sh[k]  = {r_mag[k][iywm_pkg::MAG_W-2:0], 1'b0};
            if (rem_sh[k] >= {1'b0, r_w}) begin
                rem_sh[k] = rem_sh[k] - {1'b0, r_w};
                mag_sh[k][0] = 1'b1;
            end
            mean[k] = r_sgn[k] ? 16'(-r_mag[k][15:0]) : r_mag[k][15:0];
        end
    end

    // control state: configuration, yaw, write slot, entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size <= iywm_pkg::WIN_RESET;
            r_yaw_gain <= iywm_pkg::GAIN_RESET;
            r_yaw      <= '0;
            r_slot     <= '0;
            r_valid    <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    iywm_pkg::REG_WINDOW_SIZE: r_win_size <= i_cfg_data[6:0];
                    iywm_pkg::REG_YAW_GAIN:    r_yaw_gain <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.yaw_add) begin
                r_yaw <= r_yaw + r_prod2[37:6];
            end
            if (i_cmd.rot3) begin
                r_valid[r_slot] <= 1'b1;
                r_slot <= (slot_inc >= r_w) ? '0 : slot_inc[iywm_pkg::RING_AW-1:0];
            end
            r_rd_vld <= i_cmd.sum_rd && r_valid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
            if (r_win_size == 7'd0) begin
                r_w <= 7'd1;
            end else if (r_win_size > iywm_pkg::WIN_MAX) begin
                r_w <= iywm_pkg::WIN_MAX;
            end else begin
                r_w <= r_win_size;
            end
        end
        if (i_cmd.mul1) begin
            r_prod1 <= r_in.gyro_z * $signed({1'b0, r_in.elapsed_ms});
        end
        if (i_cmd.mul2) begin
            r_prod2 <= r_prod1 * $signed({1'b0, r_yaw_gain});
        end
        if (i_cmd.cordic_init) begin
            r_x   <= iywm_pkg::CORDIC_X0;
            r_y   <= '0;
            r_z   <= 34'($signed(fold));
            r_neg <= fold_neg;
        end
        if (i_cmd.cordic_step) begin
            if (!r_z[33]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_s;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_s;
            end
        end
        if (i_cmd.scale) begin
            r_cos <= r_neg ? -trig_round(r_x) : trig_round(r_x);
            r_sin <= r_neg ? -trig_round(r_y) : trig_round(r_y);
        end
        if (i_cmd.rot1) begin
            r_p0 <= r_cos * r_in.accel_x;
            r_p1 <= r_sin * r_in.accel_y;
        end
        if (i_cmd.rot2) begin
            r_rx <= rot_round(sum01);
            r_p0 <= r_cos * r_in.accel_y;
            r_p1 <= r_sin * r_in.accel_x;
        end
        for (int k = 0; k < NCH; k++) begin
            if (i_cmd.rot3) begin
                r_acc[k] <= '0;
            end else if (i_cmd.sum_acc) begin
                r_acc[k] <= r_acc[k] + acc_add[k];
            end
            if (i_cmd.div_init) begin
                r_sgn[k] <= r_acc[k][iywm_pkg::SUM_W-1];
                r_mag[k] <= r_acc[k][iywm_pkg::SUM_W-1]
                    ? iywm_pkg::MAG_W'(-r_acc[k]) : iywm_pkg::MAG_W'(r_acc[k]);
                r_rem[k] <= '0;
            end else if (i_cmd.div_step) begin
                r_mag[k] <= mag_sh[k];
                r_rem[k] <= rem_sh[k];
            end
        end
        if (i_cmd.out_load) begin
            r_out.mean_accel_x <= mean[0];
            r_out.mean_accel_y <= mean[1];
            r_out.mean_rate_x  <= mean[2];
            r_out.mean_rate_y  <= mean[3];
            r_out.mean_rate_z  <= mean[4];
            r_out.heading      <= r_yaw;
        end
    end

    assign o_sts.w    = r_w;
    assign o_out_data = r_out;
endmodule
`default_nettype wire

FILE: hdl/imu_yaw_compensated_window_mean.sv
// From input transfer to result it runs yaw integration, the 16-step CORDIC, the rotation,
// a ring read over the clamped window w for the sums and the 22-step divider.
// Input stalls while an item is in flight, so the next item is taken only once this one is through.
// A finished result waits in the output register without blocking the next input transfer.
// Reset (sync, active low) clears yaw, write slot and ring valid bits and sets the config registers to defaults.
`default_nettype none
module imu_yaw_compensated_window_mean (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [7:0]     i_cfg_index,
    input  wire logic [15:0]    i_cfg_data,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire iywm_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output iywm_pkg::t_out      o_out_data
);
    iywm_pkg::t_cmd cmd;
    iywm_pkg::t_sts sts;

    iywm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    iywm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );
endmodule
`default_nettype wire

FILE: hdl/iywm_checker.sv
// Port-level checker for the IMU yaw-compensated window mean, bound to the top.
// Depends on iywm_pkg and the assertion macro header.
`default_nettype none
`include "imu_yaw_compensated_window_mean_assert.svh"
module iywm_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_stall,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire iywm_pkg::t_out o_out_data
);
    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    `IYWM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `IYWM_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))
    // one item in flight: after a transfer the input side closes
    `IYWM_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, in_xfer, o_in_stall)
    // a result never appears right behind its input transfer
    `IYWM_ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, in_xfer, !$rose(o_out_valid))
endmodule

bind imu_yaw_compensated_window_mean iywm_checker u_iywm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);
`default_nettype wire

FILE: verif/tb.sv
// Testbench for imu_yaw_compensated_window_mean: yaw integration, rotation and window means.
// Depends on iywm_pkg and the block's RTL; predicts each result and checks every transfer.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [7:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    iywm_pkg::t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    iywm_pkg::t_out o_out_data;

    imu_yaw_compensated_window_mean dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor state
    logic [6:0] win_reg;
    logic [15:0] gain_reg;
    logic [31:0] yaw_now;
    int unsigned slot_now;
    int acc_ring [64][2];
    int rt_ring [64][3];

    iywm_pkg::t_in  sample_q [$];
    iywm_pkg::t_out mean_q [$];
    int errors = 0;
    int results_seen = 0;
    int sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_recv = 0;
    bit done = 0;
    int quiet = 0;

    const longint ATAN [16] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4,
        'h028B0D43, 'h0145D7E1, 'h00A2F61E, 'h00517C55,
        'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D};

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void cordic_sincos(input logic [31:0] ang, output longint c,
                                          output longint s);
        logic [31:0] a;
        bit flip;
        longint x, y, z, xs, ys;
        a = ang;
        flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
        if (flip) a = a + 32'h8000_0000;
        x = 652032874;
        y = 0;
        z = longint'($signed(a));
        for (int i = 0; i < 16; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= ATAN[i];
            end else begin
                x += ys; y -= xs; z += ATAN[i];
            end
        end
        c = clip(floor_shift(x + 16384, 15), -32767, 32767);
        s = clip(floor_shift(y + 16384, 15), -32767, 32767);
        if (flip) begin
            c = -c; s = -s;
        end
    endfunction

    function automatic iywm_pkg::t_out predict_means(iywm_pkg::t_in smp);
        iywm_pkg::t_out r;
        int unsigned w;
        longint prod, c, s, rx, ry;
        longint sums [5];
        w = (win_reg < 1) ? 1 : (win_reg > 64 ? 64 : win_reg);
        prod = longint'(smp.gyro_z) * longint'(smp.elapsed_ms) * longint'(gain_reg);
        yaw_now = yaw_now + 32'(floor_shift(prod, 6));
        cordic_sincos(yaw_now, c, s);
        rx = clip(floor_shift(c * smp.accel_x + s * smp.accel_y + 16384, 15), -32768, 32767);
        ry = clip(floor_shift(c * smp.accel_y - s * smp.accel_x + 16384, 15), -32768, 32767);
        if (slot_now < 64) begin
            acc_ring[slot_now] = '{int'(rx), int'(ry)};
            rt_ring[slot_now] = '{smp.gyro_x, smp.gyro_y, smp.gyro_z};
        end
        slot_now++;
        if (slot_now > w - 1) slot_now = 0;
        foreach (sums[k]) sums[k] = 0;
        for (int i = 0; i < w; i++) begin
            sums[0] += acc_ring[i][0];
            sums[1] += acc_ring[i][1];
            sums[2] += rt_ring[i][0];
            sums[3] += rt_ring[i][1];
            sums[4] += rt_ring[i][2];
        end
        r.mean_accel_x = 16'(sums[0] / longint'(w));
        r.mean_accel_y = 16'(sums[1] / longint'(w));
        r.mean_rate_x  = 16'(sums[2] / longint'(w));
        r.mean_rate_y  = 16'(sums[3] / longint'(w));
        r.mean_rate_z  = 16'(sums[4] / longint'(w));
        r.heading = yaw_now;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
    endtask

    // Driver: present the queue head; predict and drop it at each transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                mean_q.push_back(predict_means(i_in_data));
                void'(sample_q.pop_front());
                sent++;
            end
            // hold a stalled transfer, otherwise pick the next one
            if (!(i_in_valid && o_in_stall)) begin
                if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= sample_q[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                iywm_pkg::t_out want;
                results_seen++;
                if (mean_q.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    want = mean_q.pop_front();
                    if (o_out_data.mean_accel_x !== want.mean_accel_x)
                        report_mismatch("mean_accel_x", o_out_data.mean_accel_x, want.mean_accel_x);
                    if (o_out_data.mean_accel_y !== want.mean_accel_y)
                        report_mismatch("mean_accel_y", o_out_data.mean_accel_y, want.mean_accel_y);
                    if (o_out_data.mean_rate_x !== want.mean_rate_x)
                        report_mismatch("mean_rate_x", o_out_data.mean_rate_x, want.mean_rate_x);
                    if (o_out_data.mean_rate_y !== want.mean_rate_y)
                        report_mismatch("mean_rate_y", o_out_data.mean_rate_y, want.mean_rate_y);
                    if (o_out_data.mean_rate_z !== want.mean_rate_z)
                        report_mismatch("mean_rate_z", o_out_data.mean_rate_z, want.mean_rate_z);
                    if (o_out_data.heading !== want.heading)
                        report_mismatch("heading", o_out_data.heading, want.heading);
                end
            end
            i_out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: count cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n || done)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == iywm_pkg::REG_WINDOW_SIZE) win_reg = val[6:0];
        else if (idx == iywm_pkg::REG_YAW_GAIN) gain_reg = val;
    endtask

    // Wait for every expected result, then let the block settle
    task automatic drain();
        while (sample_q.size() > 0 || mean_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic iywm_pkg::t_in random_sample();
        iywm_pkg::t_in s;
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        s = bits[89:0];
        case ($urandom_range(3))
            0: s.elapsed_ms = 10'($urandom_range(20));
            1: s.gyro_z = 16'($signed(16'($urandom_range(400))) - 16'sd200);
            default: ;
        endcase
        return s;
    endfunction

    task automatic queue_random(int n);
        repeat (n) sample_q.push_back(random_sample());
    endtask

    initial begin
        iywm_pkg::t_in d;
        win_reg = iywm_pkg::WIN_RESET;
        gain_reg = iywm_pkg::GAIN_RESET;
        yaw_now = '0;
        slot_now = 0;
        foreach (acc_ring[i]) begin
            acc_ring[i] = '{0, 0};
            rt_ring[i] = '{0, 0, 0};
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes of every field at reset settings
        d = '0;
        sample_q.push_back(d);
        d = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 10'h3ff};
        sample_q.push_back(d);
        d = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 10'h3ff};
        sample_q.push_back(d);
        d = '{16'sh8000, 16'sh7fff, 16'sh0001, 16'sh8000, 16'sh7fff, 10'd1};
        sample_q.push_back(d);
        d = '{16'sh7fff, 16'sh8000, 16'shffff, 16'sh7fff, 16'sh8000, 10'd512};
        sample_q.push_back(d);
        // step yaw backwards through three quadrants
        for (int q = 0; q < 6; q++) begin
            d = '{16'sh1234, -16'sh1234, 16'sd22000, 16'sh7fff, 16'sh8000, 10'd500};
            sample_q.push_back(d);
        end
        drain();

        // Window of 0 acts as 1; unused register index is ignored
        write_reg(iywm_pkg::REG_WINDOW_SIZE, 16'd0);
        write_reg(8'd2, 16'hffff);
        write_reg(8'hff, 16'h0001);
        write_reg(iywm_pkg::REG_YAW_GAIN, 16'hffff);
        queue_random(6);
        drain();
        // Oversize window clamps to the ring; grow then shrink the window
        write_reg(iywm_pkg::REG_WINDOW_SIZE, 16'h007f);
        queue_random(8);
        drain();
        write_reg(iywm_pkg::REG_WINDOW_SIZE, 16'd64);
        write_reg(iywm_pkg::REG_YAW_GAIN, 16'd0);
        queue_random(70);
        drain();
        write_reg(iywm_pkg::REG_WINDOW_SIZE, 16'd3);
        write_reg(iywm_pkg::REG_YAW_GAIN, 16'd1);
        queue_random(10);
        drain();

        // Random phases under each idling mode
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 59 : 38) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 59 : 38) : 0;
            write_reg(iywm_pkg::REG_WINDOW_SIZE, 16'($urandom_range(16, 1)));
            write_reg(iywm_pkg::REG_YAW_GAIN, 16'($urandom));
            queue_random(70);
            drain();
        end

        // Long receiver hold while samples keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(iywm_pkg::REG_WINDOW_SIZE, 16'd8);
        write_reg(iywm_pkg::REG_YAW_GAIN, iywm_pkg::GAIN_RESET);
        hold_recv = 1;
        queue_random(20);
        repeat (800) @(posedge i_clk);
        hold_recv = 0;
        drain();
        done = 1;

        $display("covered %0d samples, %0d results checked, window sizes 0 to 127",
                 sent, results_seen);
        $display("gain extremes, unused register writes and all idling phases exercised");
        if (errors == 0 && mean_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
